FILE: rtl/pmff_pkg.sv
// ----------------------------------------------------------------------------
// pmff_pkg
// Types and fixed constants shared by the physical memory and free-frame
// stack block.
// ----------------------------------------------------------------------------
package pmff_pkg;

    localparam int STACK_DEPTH    = 256;
    localparam int FRAME_W        = 8;
    localparam int COUNT_W        = 9;
    localparam int ADDR_W         = 16;
    localparam int DATA_W         = 8;
    localparam int CMD_W          = 3;
    localparam int STATUS_W       = 3;
    localparam int MEM_SIZE_W     = 17;
    localparam int CFG_IDX_W      = 1;
    localparam int MEM_SIZE_RESET = 65536;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_MODE = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 3'd0,
        CMD_WRITE  = 3'd1,
        CMD_TAKE   = 3'd2,
        CMD_RETURN = 3'd3,
        CMD_FORMAT = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_RANGE     = 3'd2,
        ST_FULL      = 3'd3,
        ST_NO_FRAMES = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_COUNT,
        S_FILL
    } t_state;

endpackage

FILE: rtl/phys_memory_with_free_frame_stack.sv
// ----------------------------------------------------------------------------
// phys_memory_with_free_frame_stack
// Byte-addressed physical memory with a last-in-first-out stack of free
// page frame numbers.
// ----------------------------------------------------------------------------
// Usage:
//   A command word is taken at a rising edge with start high and busy low.
//   The command (read, write, take frame, return frame, format) executes
//   in S_EXEC after acceptance (format goes on through S_COUNT and S_FILL),
//   and its single result word appears on o_read_data, o_frame_out and
//   o_status for exactly one cycle, marked by o_done, in the cycle after
//   its last state. The receiver cannot stall it. For read, write, take
//   and return both RAMs are read at the accepting edge, S_EXEC writes
//   back and the registered outputs show the result. busy is low while
//   o_done is shown, so the next command can be taken while it shows.
//   Format counts frames one per cycle against mem_size, then writes the
//   stack one entry per cycle. After reset the byte RAM is cleared one entry
//   per cycle with busy high, and the stack is rebuilt during that pass.
//   Configuration writes (mem_size, random_mode) take effect at once and
//   are accepted at any time, including during the clearing pass.
// ----------------------------------------------------------------------------
module phys_memory_with_free_frame_stack #(
    parameter int MEM_BYTES  = 65536,
    parameter int PAGE_BYTES = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pmff_pkg::CMD_W-1:0]        i_command,
    input  logic [pmff_pkg::ADDR_W-1:0]       i_address,
    input  logic [pmff_pkg::DATA_W-1:0]       i_write_data,
    input  logic [pmff_pkg::FRAME_W-1:0]      i_frame_in,
    input  logic                              i_cfg_we,
    input  logic [pmff_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pmff_pkg::MEM_SIZE_W-1:0]   i_cfg_wdata,
    output logic                              o_done,
    output logic [pmff_pkg::DATA_W-1:0]       o_read_data,
    output logic [pmff_pkg::FRAME_W-1:0]      o_frame_out,
    output logic [pmff_pkg::STATUS_W-1:0]     o_status
);

    import pmff_pkg::*;

    localparam int AW         = $clog2(MEM_BYTES);
    localparam int CLR_W      = AW + 1;
    localparam int SP_W       = $clog2(STACK_DEPTH);
    localparam int RST_FRAMES = (MEM_SIZE_RESET / PAGE_BYTES > STACK_DEPTH) ?
                                STACK_DEPTH : (MEM_SIZE_RESET / PAGE_BYTES);
    localparam int ACC_W      = $clog2((STACK_DEPTH + 1) * PAGE_BYTES) + 1;
    localparam int CMP_W      = (ACC_W > MEM_SIZE_W) ? ACC_W : MEM_SIZE_W;

    localparam logic [FRAME_W-1:0] RST_TOP   = FRAME_W'(RST_FRAMES - 1);
    localparam logic [AW-1:0]      CLR_LAST  = AW'(MEM_BYTES - 1);
    localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(STACK_DEPTH);

    t_state r_state, n_state;

    logic [MEM_SIZE_W-1:0] r_mem_size;
    logic                  r_random_mode;
    logic [ADDR_W-1:0]     r_cursor, n_cursor;
    logic [COUNT_W-1:0]    r_count, n_count;

    logic [CMD_W-1:0]      r_command;
    logic [ADDR_W-1:0]     r_address;
    logic [DATA_W-1:0]     r_write_data;
    logic [FRAME_W-1:0]    r_frame_in;

    logic [AW-1:0]         r_clr_idx, n_clr_idx;
    logic [COUNT_W-1:0]    r_fcnt, n_fcnt;
    logic [SP_W-1:0]       r_fidx, n_fidx;
    logic [ACC_W-1:0]      r_acc, n_acc;
    logic [ACC_W-1:0]      acc_next;

    logic                  r_done, n_done;
    logic [DATA_W-1:0]     r_read_data, n_read_data;
    logic [FRAME_W-1:0]    r_frame_out, n_frame_out;
    logic [STATUS_W-1:0]   r_status, n_status;

    logic                  accept;
    logic                  addr_ok;

    logic                  byte_we;
    logic [AW-1:0]         byte_waddr;
    logic [DATA_W-1:0]     byte_wdata;
    logic [AW-1:0]         byte_raddr;
    logic [DATA_W-1:0]     byte_rdata;

    logic                  stk_we;
    logic [SP_W-1:0]       stk_waddr;
    logic [FRAME_W-1:0]    stk_wdata;
    logic [SP_W-1:0]       stk_raddr;
    logic [FRAME_W-1:0]    stk_rdata;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Both RAMs are read at the acceptance edge; the words arrive for S_EXEC.
    assign byte_raddr = AW'(i_address);
    assign stk_raddr  = SP_W'(r_count - COUNT_W'(1));

    assign addr_ok  = (MEM_SIZE_W'(r_address) < r_mem_size) &&
                      ({16'b0, r_address} < 32'(MEM_BYTES));
    assign acc_next = r_acc + ACC_W'(PAGE_BYTES);

    pmff_ram #(
        .DEPTH(MEM_BYTES),
        .WIDTH(DATA_W)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (byte_waddr),
        .i_wdata (byte_wdata),
        .i_raddr (byte_raddr),
        .o_rdata (byte_rdata)
    );

    pmff_ram #(
        .DEPTH(STACK_DEPTH),
        .WIDTH(FRAME_W)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_mem_size    <= MEM_SIZE_W'(MEM_SIZE_RESET);
            r_random_mode <= 1'b1;
            r_cursor      <= '0;
            r_count       <= COUNT_W'(RST_FRAMES);
            r_clr_idx     <= '0;
            r_fcnt        <= '0;
            r_fidx        <= '0;
            r_acc         <= '0;
            r_done        <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cursor  <= n_cursor;
            r_count   <= n_count;
            r_clr_idx <= n_clr_idx;
            r_fcnt    <= n_fcnt;
            r_fidx    <= n_fidx;
            r_acc     <= n_acc;
            r_done    <= n_done;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MEM_SIZE) begin
                    r_mem_size <= i_cfg_wdata;
                end else begin
                    r_random_mode <= i_cfg_wdata[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_data <= n_read_data;
        r_frame_out <= n_frame_out;
        r_status    <= n_status;
        if (accept) begin
            r_command    <= i_command;
            r_address    <= i_address;
            r_write_data <= i_write_data;
            r_frame_in   <= i_frame_in;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_count     = r_count;
        n_clr_idx   = r_clr_idx;
        n_fcnt      = r_fcnt;
        n_fidx      = r_fidx;
        n_acc       = r_acc;
        n_done      = 1'b0;
        n_read_data = '0;
        n_frame_out = '0;
        n_status    = ST_OK;
        byte_we     = 1'b0;
        byte_waddr  = AW'(r_address);
        byte_wdata  = r_write_data;
        stk_we      = 1'b0;
        stk_waddr   = r_count[SP_W-1:0];
        stk_wdata   = r_frame_in;

        unique case (r_state)
            S_CLEAR: begin
                // Zero the byte RAM and lay out the reset frame list.
                byte_we    = 1'b1;
                byte_waddr = r_clr_idx;
                byte_wdata = '0;
                if ({1'b0, r_clr_idx} < CLR_W'(RST_FRAMES)) begin
                    stk_we    = 1'b1;
                    stk_waddr = r_clr_idx[SP_W-1:0];
                    stk_wdata = RST_TOP - r_clr_idx[FRAME_W-1:0];
                end
                n_clr_idx = r_clr_idx + AW'(1);
                if (r_clr_idx == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                unique case (t_cmd'(r_command))
                    CMD_READ, CMD_WRITE: begin
                        if (!addr_ok) begin
                            n_status = ST_RANGE;
                        end else begin
                            if (t_cmd'(r_command) == CMD_READ) begin
                                n_read_data = byte_rdata;
                            end else begin
                                byte_we = 1'b1;
                            end
                            if (!r_random_mode) begin
                                n_cursor = r_address;
                            end
                        end
                    end
                    CMD_TAKE: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_frame_out = stk_rdata;
                            n_count     = r_count - COUNT_W'(1);
                        end
                    end
                    CMD_RETURN: begin
                        if (r_count >= FULL_CNT) begin
                            n_status = ST_FULL;
                        end else begin
                            stk_we  = 1'b1;
                            n_count = r_count + COUNT_W'(1);
                        end
                    end
                    CMD_FORMAT: begin
                        n_done  = 1'b0;
                        n_state = S_COUNT;
                        n_fcnt  = '0;
                        n_acc   = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_COUNT: begin
                // One frame per cycle while the next whole page still fits and the count is below the stack depth.
                if ((r_fcnt != FULL_CNT) &&
                    (CMP_W'(acc_next) <= CMP_W'(r_mem_size))) begin
                    n_fcnt = r_fcnt + COUNT_W'(1);
                    n_acc  = acc_next;
                end else if (r_fcnt == '0) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ST_NO_FRAMES;
                end else begin
                    n_state = S_FILL;
                    n_fidx  = '0;
                end
            end
            S_FILL: begin
                stk_we    = 1'b1;
                stk_waddr = r_fidx;
                stk_wdata = FRAME_W'(r_fcnt - COUNT_W'(1) - {1'b0, r_fidx});
                n_fidx    = r_fidx + SP_W'(1);
                if ({1'b0, r_fidx} == r_fcnt - COUNT_W'(1)) begin
                    n_state = S_IDLE;
                    n_count = r_fcnt;
                    n_done  = 1'b1;
                end
            end
        endcase
    end

    assign o_done      = r_done;
    assign o_read_data = r_read_data;
    assign o_frame_out = r_frame_out;
    assign o_status    = r_status;

endmodule

FILE: rtl/pmff_ram.sv
// ----------------------------------------------------------------------------
// pmff_ram
// Simple dual-port synchronous RAM: one write port, one read port with the
// read word registered.
// ----------------------------------------------------------------------------
module pmff_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Physical memory and free-frame stack testbench
// Drives read, write, take-frame, return-frame and format commands into the
// block through its start/busy handshake. A shadow copy of the byte store and
// of the free-frame stack works out the one result word that each command
// gives. Each word that the block strobes out is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
    import pmff_pkg::*;

    localparam int MEM_BYTES      = 65536;
    localparam int PAGE_BYTES     = 256;
    localparam int WATCHDOG_LIMIT = 262144;
    localparam int DRAIN_CYCLES   = 32;
    localparam int PHASES         = 11;
    localparam int PHASE_ITEMS    = 118;
    localparam int TOUCHED_MAX    = 32;
    localparam int FIRST_UNUSED   = int'(CMD_FORMAT) + 1;
    localparam int LAST_UNUSED    = 2**CMD_W - 1;

    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [MEM_SIZE_W-1:0] cfg_data;
        logic [CMD_W-1:0]      command;
        logic [ADDR_W-1:0]     address;
        logic [DATA_W-1:0]     write_data;
        logic [FRAME_W-1:0]    frame_in;
        logic [7:0]            gap;
    } t_mem_word;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic [FRAME_W-1:0] frame_out;
        t_status            status;
    } t_mem_result;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic [CMD_W-1:0]      i_command   = '0;
    logic [ADDR_W-1:0]     i_address   = '0;
    logic [DATA_W-1:0]     i_write_data = '0;
    logic [FRAME_W-1:0]    i_frame_in  = '0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [MEM_SIZE_W-1:0] i_cfg_wdata = '0;
    logic                  o_done;
    logic [DATA_W-1:0]     o_read_data;
    logic [FRAME_W-1:0]    o_frame_out;
    logic [STATUS_W-1:0]   o_status;

    phys_memory_with_free_frame_stack #(
        .MEM_BYTES  (MEM_BYTES),
        .PAGE_BYTES (PAGE_BYTES)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_frame_in   (i_frame_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_read_data  (o_read_data),
        .o_frame_out  (o_frame_out),
        .o_status     (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow state of the block.
    logic [DATA_W-1:0]     shadow_mem [MEM_BYTES];
    logic [FRAME_W-1:0]    shadow_stack [STACK_DEPTH];
    int                    shadow_count;
    logic [ADDR_W-1:0]     shadow_cursor;
    logic [MEM_SIZE_W-1:0] cfg_mem_size;
    logic                  cfg_random_mode;

    t_mem_word   pending_words [$];
    t_mem_result expected_results [$];
    t_mem_word   in_flight;
    int          gap_left;
    int          mismatches;
    int          idle_cycles;

    // Stimulus bookkeeping.
    bit                    steady_phase;
    logic [MEM_SIZE_W-1:0] gen_mem_size;
    logic [ADDR_W-1:0]     touched [$];

    function automatic bit rebuild_free_list(logic [MEM_SIZE_W-1:0] size);
        int n_frames;
        n_frames = size / PAGE_BYTES;
        if (n_frames == 0)
            return 1'b0;
        if (n_frames > STACK_DEPTH)
            n_frames = STACK_DEPTH;
        for (int i = 0; i < n_frames; i++)
            shadow_stack[i] = FRAME_W'(n_frames - 1 - i);
        shadow_count = n_frames;
        return 1'b1;
    endfunction

    function automatic t_mem_result execute_word(t_mem_word w);
        t_mem_result r;
        r = '{read_data: '0, frame_out: '0, status: ST_OK};
        case (w.command)
            CMD_READ, CMD_WRITE: begin
                if ({1'b0, w.address} >= cfg_mem_size || w.address >= MEM_BYTES) begin
                    r.status = ST_RANGE;
                end else begin
                    if (w.command == CMD_READ)
                        r.read_data = shadow_mem[w.address];
                    else
                        shadow_mem[w.address] = w.write_data;
                    if (!cfg_random_mode)
                        shadow_cursor = w.address;
                end
            end
            CMD_TAKE: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    shadow_count--;
                    r.frame_out = shadow_stack[shadow_count];
                end
            end
            CMD_RETURN: begin
                if (shadow_count >= STACK_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_stack[shadow_count] = w.frame_in;
                    shadow_count++;
                end
            end
            CMD_FORMAT: begin
                if (!rebuild_free_list(cfg_mem_size))
                    r.status = ST_NO_FRAMES;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_phase || roll < 60)
            return 8'd0;
        if (roll < 92)
            return 8'($urandom_range(1, 3));
        return 8'($urandom_range(10, 60));
    endfunction

    task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                             logic [DATA_W-1:0] wdata, logic [FRAME_W-1:0] frame);
        t_mem_word w;
        w = '0;
        w.command    = cmd;
        w.address    = addr;
        w.write_data = wdata;
        w.frame_in   = frame;
        w.gap        = pick_gap();
        pending_words.push_back(w);
    endtask

    task automatic queue_cfg(logic [CFG_IDX_W-1:0] idx, logic [MEM_SIZE_W-1:0] data);
        t_mem_word w;
        w = '0;
        w.is_cfg   = 1'b1;
        w.cfg_idx  = idx;
        w.cfg_data = data;
        pending_words.push_back(w);
        if (idx == CFG_MEM_SIZE)
            gen_mem_size = data;
    endtask

    // Mostly addresses already written or inside the configured size, so that
    // reads come back with data; the rest spans the whole field.
    function automatic logic [ADDR_W-1:0] pick_addr();
        int roll;
        int span;
        roll = $urandom_range(0, 99);
        span = (gen_mem_size < MEM_BYTES) ? int'(gen_mem_size) : MEM_BYTES;
        if (roll < 40 && touched.size() > 0)
            return touched[$urandom_range(0, touched.size() - 1)];
        if (roll < 85 && span > 0)
            return ADDR_W'($urandom_range(0, span - 1));
        return ADDR_W'($urandom);
    endfunction

    function automatic logic [MEM_SIZE_W-1:0] pick_mem_size();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return MEM_SIZE_W'(PAGE_BYTES - 1);
            2: return MEM_SIZE_W'(PAGE_BYTES);
            3: return MEM_SIZE_W'($urandom_range(PAGE_BYTES + 1, 16 * PAGE_BYTES));
            4: return MEM_SIZE_W'(MEM_BYTES - 1);
            5: return MEM_SIZE_W'(MEM_BYTES);
            6: return '1;
            default: return MEM_SIZE_W'($urandom);
        endcase
    endfunction

    // Driver: one command word at a time, held on start until busy is low.
    // Register writes wait until the block is idle and nothing is owed.
    always @(posedge i_clk) begin : drive_words
        t_mem_word head;
        logic      raise_start;
        logic      raise_we;
        if (i_rst_n) begin
            raise_start = start;
            raise_we    = 1'b0;
            if (start && !busy) begin
                expected_results.push_back(execute_word(in_flight));
                raise_start = 1'b0;
                gap_left    = in_flight.gap;
            end else if (!start && gap_left > 0) begin
                gap_left--;
            end
            if (!raise_start && gap_left == 0 && pending_words.size() > 0) begin
                head = pending_words[0];
                if (!head.is_cfg) begin
                    void'(pending_words.pop_front());
                    in_flight    = head;
                    raise_start  = 1'b1;
                    i_command    <= head.command;
                    i_address    <= head.address;
                    i_write_data <= head.write_data;
                    i_frame_in   <= head.frame_in;
                end else if (expected_results.size() == 0 && !busy && !o_done) begin
                    void'(pending_words.pop_front());
                    if (head.cfg_idx == CFG_MEM_SIZE)
                        cfg_mem_size = head.cfg_data;
                    else
                        cfg_random_mode = head.cfg_data[0];
                    raise_we    = 1'b1;
                    i_cfg_idx   <= head.cfg_idx;
                    i_cfg_wdata <= head.cfg_data;
                end
            end
            start    <= raise_start;
            i_cfg_we <= raise_we;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_mem_result want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $error("result word with none expected: read_data %0d frame_out %0d status %0d",
                       o_read_data, o_frame_out, o_status);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (o_read_data !== want.read_data) begin
                    $error("read_data: expected %0d, actual %0d", want.read_data, o_read_data);
                    mismatches++;
                end
                if (o_frame_out !== want.frame_out) begin
                    $error("frame_out: expected %0d, actual %0d", want.frame_out, o_frame_out);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    mismatches++;
                end
            end
        end
    end

    // The clearing pass after reset accepts no command while it clears the byte RAM.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int                 roll;
        int                 take_share;
        logic [ADDR_W-1:0]  addr;
        mismatches      = 0;
        idle_cycles     = 0;
        gap_left        = 0;
        shadow_count    = 0;
        shadow_cursor   = '0;
        cfg_mem_size    = MEM_SIZE_W'(MEM_SIZE_RESET);
        cfg_random_mode = 1'b1;
        gen_mem_size    = MEM_SIZE_W'(MEM_SIZE_RESET);
        steady_phase    = 1'b0;
        for (int i = 0; i < MEM_BYTES; i++)
            shadow_mem[i] = '0;
        void'(rebuild_free_list(cfg_mem_size));

        // Directed: store extremes, stack order, unused codes, tiny and empty
        // sizes, a size past the store, a full list, sequential mode.
        queue_cmd(CMD_READ,  '0, '0, '0);
        queue_cmd(CMD_WRITE, '1, '1, '0);
        queue_cmd(CMD_READ,  '1, '0, '1);
        queue_cmd(CMD_TAKE,  '0, '0, '0);
        queue_cmd(CMD_RETURN, '0, '0, '1);
        queue_cmd(CMD_TAKE,  '0, '0, '0);
        queue_cmd(CMD_RETURN, '0, '0, '0);
        queue_cmd(CMD_FORMAT, '0, '0, '0);
        queue_cmd(CMD_TAKE,  '0, '0, '0);
        for (int c = FIRST_UNUSED; c <= LAST_UNUSED; c++)
            queue_cmd(CMD_W'(c), '1, '1, '1);
        queue_cfg(CFG_MEM_SIZE, MEM_SIZE_W'(PAGE_BYTES));
        queue_cmd(CMD_FORMAT, '0, '0, '0);
        queue_cmd(CMD_TAKE,  '0, '0, '0);
        queue_cmd(CMD_TAKE,  '0, '0, '0);
        queue_cmd(CMD_READ,  ADDR_W'(PAGE_BYTES), '0, '0);
        queue_cmd(CMD_READ,  ADDR_W'(PAGE_BYTES - 1), '0, '0);
        queue_cfg(CFG_MEM_SIZE, '0);
        queue_cmd(CMD_FORMAT, '0, '0, '0);
        queue_cmd(CMD_TAKE,  '0, '0, '0);
        queue_cmd(CMD_WRITE, '0, '1, '0);
        queue_cfg(CFG_MEM_SIZE, '1);
        queue_cfg(CFG_RANDOM_MODE, '0);
        queue_cmd(CMD_FORMAT, '0, '0, '0);
        queue_cmd(CMD_RETURN, '0, '0, '1);
        queue_cmd(CMD_WRITE, '1, 8'h5A, '0);
        queue_cmd(CMD_READ,  '1, '0, '0);

        // Random phases: each picks a size, a mode, a take/return balance
        // that drives the list toward empty or full, and an idling style.
        for (int p = 0; p < PHASES; p++) begin
            queue_cfg(CFG_MEM_SIZE, pick_mem_size());
            queue_cfg(CFG_RANDOM_MODE, MEM_SIZE_W'($urandom));
            steady_phase = ($urandom_range(0, 3) == 0);
            take_share   = $urandom_range(5, 41);
            if ($urandom_range(0, 1))
                queue_cmd(CMD_FORMAT, ADDR_W'($urandom), DATA_W'($urandom), FRAME_W'($urandom));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                addr = pick_addr();
                if (roll < 25) begin
                    queue_cmd(CMD_READ, addr, DATA_W'($urandom), FRAME_W'($urandom));
                end else if (roll < 50) begin
                    queue_cmd(CMD_WRITE, addr, DATA_W'($urandom), FRAME_W'($urandom));
                    touched.push_back(addr);
                    if (touched.size() > TOUCHED_MAX)
                        void'(touched.pop_front());
                end else if (roll < 50 + take_share) begin
                    queue_cmd(CMD_TAKE, addr, DATA_W'($urandom), FRAME_W'($urandom));
                end else if (roll < 96) begin
                    queue_cmd(CMD_RETURN, addr, DATA_W'($urandom), FRAME_W'($urandom));
                end else if (roll < 98) begin
                    queue_cmd(CMD_FORMAT, addr, DATA_W'($urandom), FRAME_W'($urandom));
                end else begin
                    queue_cmd(CMD_W'($urandom_range(FIRST_UNUSED, LAST_UNUSED)), addr,
                              DATA_W'($urandom), FRAME_W'($urandom));
                end
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sampled mid-cycle so that a word just taken from the queue already
        // shows on start.
        while (pending_words.size() != 0 || start || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
